// ----- design/s256_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// s256_pkg
// Shared constants and functions of the SHA-256 stream hasher: the round
// constants, the initial hash values and the sigma functions of one round.
// ----------------------------------------------------------------------------
package s256_pkg;

    localparam int unsigned WordWidth   = 32;
    localparam int unsigned HashWords   = 8;
    localparam int unsigned BlockBytes  = 64;
    localparam int unsigned BlockBits   = 512;
    localparam int unsigned LengthBits  = 64;
    localparam int unsigned RoundCount  = 64;

    localparam logic [7:0] PadMarkByte  = 8'h80;
    localparam logic [5:0] LengthOffset = 6'd56;
    localparam logic [5:0] LastByteSlot = 6'd63;
    localparam logic [5:0] LastRound    = 6'd63;
    localparam logic [2:0] LastWordIdx  = 3'd7;

    typedef logic [WordWidth-1:0] t_word;

    function automatic t_word ror32(input t_word x, input int unsigned n);
        ror32 = (x >> n) | (x << (WordWidth - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word initial_hash(input logic [2:0] idx);
        case (idx)
            3'd0:    initial_hash = 32'h6a09e667;
            3'd1:    initial_hash = 32'hbb67ae85;
            3'd2:    initial_hash = 32'h3c6ef372;
            3'd3:    initial_hash = 32'ha54ff53a;
            3'd4:    initial_hash = 32'h510e527f;
            3'd5:    initial_hash = 32'h9b05688c;
            3'd6:    initial_hash = 32'h1f83d9ab;
            default: initial_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h00000000;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- design/sha256_stream_hasher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-serial SHA-256 hasher with padding, length encoding and digest output.
// ----------------------------------------------------------------------------
// The hasher takes one request per cycle while it collects bytes into a
// 512-bit block, and drops o_ready each time a block fills, while it loads
// the working variables, runs the rounds, which share one round unit, and
// adds the working variables into the hash; it takes no new byte until it
// is through with the block. An end mark then appends the padding bytes
// (up to 72 when the length spills into a second block) and runs the
// compressions, after which the eight digest words are offered on the
// output channel one per cycle while i_ready is high, and the hasher
// returns to its initial state.
module sha256_stream_hasher (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_byte_present,
    input  wire         i_end_of_message,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } t_state;

    t_state                                r_state;
    s256_pkg::t_word                       r_h [s256_pkg::HashWords];
    s256_pkg::t_word                       r_v [s256_pkg::HashWords];
    logic [s256_pkg::BlockBits-1:0]        r_blk;
    logic [5:0]                            r_count;
    logic [5:0]                            r_round;
    logic [s256_pkg::LengthBits-1:0]       r_bits;
    logic [s256_pkg::LengthBits-1:0]       r_len;
    logic                                  r_end;
    logic                                  r_mark;
    logic                                  r_len_ok;
    logic                                  r_last;
    logic [2:0]                            r_idx;

    logic [s256_pkg::LengthBits-1:0]       n_bits;
    s256_pkg::t_word                       w_cur;
    s256_pkg::t_word                       w_new;
    s256_pkg::t_word                       t1;
    s256_pkg::t_word                       t2;
    s256_pkg::t_word                       ch;
    s256_pkg::t_word                       maj;
    logic [7:0]                            pad_byte;
    logic                                  len_slot;

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_number = r_idx;
    assign o_last_word   = (r_idx == s256_pkg::LastWordIdx);

    assign n_bits = i_byte_present ? r_bits + 64'd8 : r_bits;

    // Message schedule: the oldest word of the window sits at the top.
    assign w_cur = r_blk[511:480];
    assign w_new = r_blk[511:480] + s256_pkg::small_sigma0(r_blk[479:448])
                 + r_blk[223:192] + s256_pkg::small_sigma1(r_blk[63:32]);

    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + s256_pkg::big_sigma1(r_v[4]) + ch
               + s256_pkg::round_k(r_round) + w_cur;
    assign t2  = s256_pkg::big_sigma0(r_v[0]) + maj;

    assign len_slot = r_mark && r_len_ok && (r_count >= s256_pkg::LengthOffset);

    always_comb begin
        if (!r_mark) begin
            pad_byte = s256_pkg::PadMarkByte;
        end else if (len_slot) begin
            pad_byte = r_len[63:56];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_round  <= '0;
            r_bits   <= '0;
            r_end    <= 1'b0;
            r_mark   <= 1'b0;
            r_len_ok <= 1'b0;
            r_last   <= 1'b0;
            r_idx    <= '0;
            for (int i = 0; i < s256_pkg::HashWords; i++) begin
                r_h[i] <= s256_pkg::initial_hash(3'(i));
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_bits <= n_bits;
                        r_end  <= i_end_of_message;
                        if (i_end_of_message) begin
                            r_len <= n_bits;
                        end
                        if (i_byte_present) begin
                            r_blk   <= {r_blk[503:0], i_data_byte};
                            r_count <= r_count + 6'd1;
                        end
                        if (i_byte_present && r_count == s256_pkg::LastByteSlot) begin
                            r_state <= ST_LOAD;
                        end else if (i_end_of_message) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_LOAD: begin
                    for (int i = 0; i < s256_pkg::HashWords; i++) begin
                        r_v[i] <= r_h[i];
                    end
                    r_round <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_v[7]  <= r_v[6];
                    r_v[6]  <= r_v[5];
                    r_v[5]  <= r_v[4];
                    r_v[4]  <= r_v[3] + t1;
                    r_v[3]  <= r_v[2];
                    r_v[2]  <= r_v[1];
                    r_v[1]  <= r_v[0];
                    r_v[0]  <= t1 + t2;
                    r_blk   <= {r_blk[479:0], w_new};
                    r_round <= r_round + 6'd1;
                    if (r_round == s256_pkg::LastRound) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < s256_pkg::HashWords; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    if (r_last) begin
                        r_idx   <= '0;
                        r_state <= ST_OUT;
                    end else if (r_end) begin
                        if (r_mark) begin
                            r_len_ok <= 1'b1;
                        end
                        r_state <= ST_PAD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_PAD: begin
                    r_blk   <= {r_blk[503:0], pad_byte};
                    r_count <= r_count + 6'd1;
                    if (!r_mark) begin
                        r_mark <= 1'b1;
                        if (r_count < s256_pkg::LengthOffset) begin
                            r_len_ok <= 1'b1;
                        end
                    end
                    if (len_slot) begin
                        r_len <= {r_len[55:0], 8'h00};
                        if (r_count == s256_pkg::LastByteSlot) begin
                            r_last <= 1'b1;
                        end
                    end
                    if (r_count == s256_pkg::LastByteSlot) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == s256_pkg::LastWordIdx) begin
                            r_state  <= ST_IDLE;
                            r_bits   <= '0;
                            r_end    <= 1'b0;
                            r_mark   <= 1'b0;
                            r_len_ok <= 1'b0;
                            r_last   <= 1'b0;
                            r_count  <= '0;
                            for (int i = 0; i < s256_pkg::HashWords; i++) begin
                                r_h[i] <= s256_pkg::initial_hash(3'(i));
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
